>>> rtl/core/safs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite animation frame select package
// Shared types, codes and constants for the frame select block.
// ----------------------------------------------------------------------------
package safs_pkg;

  localparam int unsigned MAX_ANIMS_DEF  = 8;
  localparam int unsigned MAX_FRAMES_DEF = 64;

  typedef enum logic [1:0] {
    OP_WR_DESC  = 2'd0,
    OP_WR_FRAME = 2'd1,
    OP_Q_TICK   = 2'd2,
    OP_Q_INDEX  = 2'd3
  } op_t;

  localparam logic [2:0] MODE_FWD_LOOP = 3'd2;
  localparam logic [2:0] MODE_PP_ONCE  = 3'd3;
  localparam logic [2:0] MODE_PP_LOOP  = 3'd4;

  typedef struct packed {
    logic [1:0]         op;
    logic [2:0]         anim_index;
    logic [15:0]        frame_slot;
    logic [6:0]         num_frames;
    logic [5:0]         loop_first;
    logic [2:0]         playback_mode;
    logic [15:0]        duration;
    logic [15:0]        cell_id;
    logic signed [31:0] tick;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [5:0]  shown_frame;
    logic [15:0] shown_cell;
  } rsp_t;

  // Divider control and status between sequencer and divider.
  typedef struct packed {
    logic        start;
    logic [47:0] dividend;
    logic [47:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] rem;
  } div_rsp_t;

endpackage

>>> rtl/core/safs_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame select remainder unit
// Restoring bit-serial remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module safs_divider (
  input  logic               clk,
  input  logic               rst,
  input  safs_pkg::div_req_t req,
  output safs_pkg::div_rsp_t rsp
);

  logic [47:0] rem;
  logic [47:0] quo;
  logic [47:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [48:0] trial;

  always_comb begin
    trial = {rem, quo[47]} - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd48;
        rem  <= '0;
        quo  <= req.dividend;
        dsr  <= req.divisor;
      end else if (busy) begin
        quo <= {quo[46:0], 1'b0};
        if (!trial[48]) rem <= trial[47:0];
        else rem <= {rem[46:0], quo[47]};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

>>> rtl/core/sprite_animation_frame_select_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite animation frame select unit
// Stores animation descriptors and frames; answers tick and index queries.
//
//  channel | direction | payload | handshake
//  req     | in        | req_t   | req_valid / req_stall
//  rsp     | out       | rsp_t   | rsp_valid / rsp_stall
//
// A tick query sweeps the frame memory one frame per cycle, forward and, in
// ping-pong modes, back to total the durations, then once more to pick the
// frame, and may run one remainder on the divider. The frame memory has a
// single read port. Reset clears only the frame counts of the descriptor
// table. The block holds req_stall high from acceptance until a write is done
// or a query result is taken.
// ----------------------------------------------------------------------------
module sprite_animation_frame_select_unit #(
  parameter int unsigned MAX_ANIMS  = safs_pkg::MAX_ANIMS_DEF,
  parameter int unsigned MAX_FRAMES = safs_pkg::MAX_FRAMES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  safs_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output safs_pkg::rsp_t   rsp
);

  localparam int AW = (MAX_ANIMS > 1) ? $clog2(MAX_ANIMS) : 1;
  localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int IW = CW + 1;  // signed walk index

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SUM   = 10'b0000000010,
    S_PLAN  = 10'b0000000100,
    S_DIV   = 10'b0000001000,
    S_DWAIT = 10'b0000010000,
    S_PICK  = 10'b0000100000,
    S_CELL  = 10'b0001000000,
    S_CELL2 = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_WR    = 10'b1000000000
  } state_t;

  state_t state;
  safs_pkg::req_t cur;

  logic [CW-1:0] cnt_tab [MAX_ANIMS];
  logic [FW-1:0] ls_tab  [MAX_ANIMS];
  logic [2:0]    md_tab  [MAX_ANIMS];

  logic [31:0] fmem [2**(AW+FW)];
  logic [31:0] rd;
  logic [AW+FW-1:0] raddr;

  logic [AW-1:0] a;
  logic          a_ok;
  logic [CW-1:0] fc;
  logic [FW-1:0] ls;
  logic [2:0]    md;
  logic          loop, pp;

  // walk state
  logic signed [IW-1:0] idx;      // address issued
  logic signed [IW-1:0] pidx;     // index of rd
  logic                 pvalid;
  logic                 phase_rev;
  logic                 prev_rev; // phase of rd
  logic [47:0]          s_fwd, s_head, s_rev, t;
  logic [47:0]          tt;
  logic signed [IW-1:0] last;
  logic                 found;
  logic [FW-1:0]        sel;
  logic                 err;
  logic [47:0]          body;

  safs_pkg::div_req_t dq;
  safs_pkg::div_rsp_t ds;

  safs_divider u_div (.clk(clk), .rst(rst), .req(dq), .rsp(ds));

  assign a    = cur.anim_index[AW-1:0];
  assign a_ok = ({29'd0, cur.anim_index} < 32'(MAX_ANIMS));
  assign fc   = cnt_tab[a];
  assign ls   = ls_tab[a];
  assign md   = md_tab[a];
  assign loop = (md == safs_pkg::MODE_FWD_LOOP) || (md == safs_pkg::MODE_PP_LOOP);
  assign pp   = (md == safs_pkg::MODE_PP_ONCE) || (md == safs_pkg::MODE_PP_LOOP);

  assign req_stall = (state != S_IDLE);
  assign rsp_valid = (state == S_OUT);

  // reverse run: from fc-2 down to re
  logic signed [IW-1:0] rs, re;
  assign rs = $signed({1'b0, fc}) - IW'(2);
  assign re = loop ? $signed({1'b0, CW'(ls)}) : '0;

  // forward end index
  logic signed [IW-1:0] fend;
  assign fend = $signed({1'b0, fc}) - IW'(1);

  logic [47:0] dur;
  assign dur = {32'd0, rd[31:16]};

  logic rd_in; // rd belongs to a valid frame
  assign rd_in = pvalid && (pidx >= 0) && (pidx < $signed({1'b0, fc}));

  always_ff @(posedge clk) begin
    rd <= fmem[raddr];
  end

  always_comb begin
    body = (s_fwd - s_head) + (pp ? s_rev : 48'd0);
    dq.start    = (state == S_DIV);
    dq.dividend = '0;
    dq.divisor  = '1;
    if (cur.op == safs_pkg::OP_Q_INDEX) begin
      dq.dividend = {32'd0, cur.frame_slot};
      dq.divisor  = {{(48-CW){1'b0}}, fc};
    end else if (body != 0) begin
      dq.dividend = t - s_head;
      dq.divisor  = body;
    end else begin
      dq.dividend = t;
      dq.divisor  = s_fwd + (pp ? s_rev : 48'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < MAX_ANIMS; i++) cnt_tab[i] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur   <= req;
            state <= S_WR;
          end
        end
        S_WR: begin
          err <= 1'b0;
          case (cur.op)
            safs_pkg::OP_WR_DESC: begin
              if (a_ok) begin
                logic [31:0] f;
                f = ({25'd0, cur.num_frames} > MAX_FRAMES) ? MAX_FRAMES
                                                           : {25'd0, cur.num_frames};
                cnt_tab[a] <= CW'(f);
                ls_tab[a]  <= ({26'd0, cur.loop_first} >= f) ? '0 : FW'(cur.loop_first);
                md_tab[a]  <= cur.playback_mode;
              end
              state <= S_IDLE;
            end
            safs_pkg::OP_WR_FRAME: begin
              if (a_ok && ({16'd0, cur.frame_slot} < 32'(MAX_FRAMES)))
                fmem[{a, cur.frame_slot[FW-1:0]}] <= {cur.duration, cur.cell_id};
              state <= S_IDLE;
            end
            default: begin
              if (!a_ok || fc == 0) begin
                err   <= 1'b1;
                state <= S_OUT;
              end else if (cur.op == safs_pkg::OP_Q_INDEX) begin
                state <= S_DIV;
              end else begin
                t      <= cur.tick[31] ? 48'd0 : {16'd0, cur.tick};
                s_fwd  <= '0; s_head <= '0; s_rev <= '0;
                idx    <= '0; pvalid <= 1'b0; phase_rev <= 1'b0;
                state  <= S_SUM;
              end
            end
          endcase
        end
        S_SUM: begin
          // sweep forward then reverse, one frame read per cycle
          pvalid   <= 1'b1;
          pidx     <= idx;
          prev_rev <= phase_rev;
          if (rd_in) begin
            if (!prev_rev) begin
              s_fwd <= s_fwd + dur;
              if (pidx < $signed({1'b0, CW'(ls)})) s_head <= s_head + dur;
            end else s_rev <= s_rev + dur;
          end
          if (!phase_rev) begin
            if (idx >= fend) begin
              phase_rev <= 1'b1;
              idx <= rs;
            end else idx <= idx + IW'(1);
          end else if (!pp || idx < re) begin
            // reverse run drained, empty or not used
            pvalid <= 1'b0;
            state  <= S_PLAN;
          end else idx <= idx - IW'(1);
        end
        S_PLAN: begin
          if (s_fwd == 0) begin
            sel <= '0;
            state <= S_CELL;
          end else begin
            if (t >= s_fwd + (pp ? s_rev : 48'd0)) begin
              if (!loop) begin
                t <= s_fwd + (pp ? s_rev : 48'd0) - 48'd1;
                state <= S_PICK;
              end else state <= S_DIV;
            end else state <= S_PICK;
            idx <= '0; pvalid <= 1'b0; phase_rev <= 1'b0;
            found <= 1'b0; last <= '0;
          end
        end
        S_DIV: state <= S_DWAIT;
        S_DWAIT: begin
          if (ds.done) begin
            if (cur.op == safs_pkg::OP_Q_INDEX) begin
              sel   <= FW'(ds.rem);
              state <= S_CELL;
            end else begin
              t <= (body != 0) ? s_head + ds.rem : ds.rem;
              state <= S_PICK;
            end
          end
        end
        S_PICK: begin
          pvalid <= 1'b1;
          pidx   <= idx;
          if (!pvalid) begin
            if (!phase_rev && pp && t >= s_fwd) begin
              // tick falls in the reverse run: restart the walk at its top
              phase_rev <= 1'b1;
              tt     <= t - s_fwd;
              idx    <= rs;
              last   <= rs;
              pvalid <= 1'b0;
            end else begin
              if (!phase_rev) tt <= t;
              idx <= phase_rev ? idx - IW'(1) : idx + IW'(1);
            end
          end else if (!found) begin
            if (rd_in) begin
              last <= pidx;
              if (dur != 0) begin
                if (tt < dur) found <= 1'b1;
                else tt <= tt - dur;
              end
            end
            if (rd_in && dur != 0 && tt < dur) begin
              sel <= FW'(pidx);
              state <= S_CELL;
            end else if (phase_rev ? (pidx <= re) : (pidx >= fend)) begin
              sel <= (rd_in ? FW'(pidx) : FW'(last));
              state <= S_CELL;
            end else idx <= phase_rev ? idx - IW'(1) : idx + IW'(1);
          end
        end
        S_CELL: state <= S_CELL2;
        S_CELL2: state <= S_OUT;
        S_OUT: if (!rsp_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // hold the selected frame on the read port until the result is taken
  always_comb begin
    raddr = {a, idx[FW-1:0]};
    if (state inside {S_CELL, S_CELL2, S_OUT}) raddr = {a, sel};
  end

  always_comb begin
    rsp.status      = err;
    rsp.shown_frame = err ? 6'd0 : 6'(sel);
    rsp.shown_cell  = err ? 16'd0 : rd[15:0];
  end

endmodule

>>> bench/tb_sprite_animation_frame_select_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite animation frame select unit testbench
// Loads animation descriptors and frames, then runs tick and index queries
// through randomly idling request and response channels. A behavioral
// predictor of the animation table checks every response in order.
// ----------------------------------------------------------------------------
module tb_sprite_animation_frame_select_unit;

  localparam int          NANIM      = int'(safs_pkg::MAX_ANIMS_DEF);
  localparam int          NFRM       = int'(safs_pkg::MAX_FRAMES_DEF);
  localparam longint      CYCLE_LIMIT = 4000000;
  localparam int          DRAIN      = 400;

  logic clk, rst;
  logic req_valid, req_stall, rsp_valid, rsp_stall;
  safs_pkg::req_t req;
  safs_pkg::rsp_t rsp;

  sprite_animation_frame_select_unit DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // predictor state
  int unsigned         anim_cnt  [NANIM];
  int unsigned         anim_ls   [NANIM];
  logic [2:0]          anim_mode [NANIM];
  logic [15:0]         frm_dur   [NANIM][NFRM];
  logic [15:0]         frm_cell  [NANIM][NFRM];

  // generator bookkeeping: which frames have been loaded
  int unsigned         gen_cnt     [NANIM];
  bit                  gen_written [NANIM][NFRM];

  safs_pkg::req_t pending_reqs[$];
  safs_pkg::rsp_t expected_rsps[$];
  int   errors = 0;
  int   send_idle, recv_idle;
  bit   taken;
  longint cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint unsigned dur_sum(int a, int from, int to, int dir);
    longint unsigned total = 0;
    for (int i = from; dir > 0 ? i <= to : i >= to; i += dir)
      if (i >= 0 && i < int'(anim_cnt[a])) total += frm_dur[a][i];
    return total;
  endfunction

  function automatic int walk_pick(int a, int from, int to, int dir, longint unsigned t);
    int last = from;
    for (int i = from; dir > 0 ? i <= to : i >= to; i += dir) begin
      if (i < 0 || i >= int'(anim_cnt[a])) continue;
      last = i;
      if (frm_dur[a][i] == 0) continue;
      if (t < frm_dur[a][i]) return i;
      t -= frm_dur[a][i];
    end
    return last;
  endfunction

  function automatic int pick_fwd(int a, longint unsigned t, bit loop);
    int fc = anim_cnt[a];
    int ls = anim_ls[a];
    longint unsigned total, head, body;
    total = dur_sum(a, 0, fc - 1, 1);
    if (total == 0) return 0;
    if (!loop) begin
      if (t >= total) t = total - 1;
    end else if (t >= total) begin
      head = dur_sum(a, 0, ls - 1, 1);
      body = dur_sum(a, ls, fc - 1, 1);
      t = (body > 0) ? head + (t - head) % body : t % total;
    end
    return walk_pick(a, 0, fc - 1, 1, t);
  endfunction

  function automatic int pick_pp(int a, longint unsigned t, bit loop);
    int fc = anim_cnt[a];
    int ls = anim_ls[a];
    int rs = fc - 2;
    int re = loop ? ls : 0;
    longint unsigned fwd, rev, seq, head, body;
    fwd = dur_sum(a, 0, fc - 1, 1);
    if (fwd == 0) return 0;
    rev = dur_sum(a, rs, re, -1);
    seq = fwd + rev;
    if (!loop) begin
      if (t >= seq) t = seq - 1;
    end else if (t >= seq) begin
      head = dur_sum(a, 0, ls - 1, 1);
      body = dur_sum(a, ls, fc - 1, 1) + rev;
      t = (body > 0) ? head + (t - head) % body : t % seq;
    end
    if (t < fwd) return walk_pick(a, 0, fc - 1, 1, t);
    return walk_pick(a, rs, re, -1, t - fwd);
  endfunction

  // update the table for one request; queries push their expected response
  function automatic void apply_request(safs_pkg::req_t r);
    int a = r.anim_index;
    int fc, ls, sel;
    longint unsigned t;
    safs_pkg::rsp_t e;
    case (safs_pkg::op_t'(r.op))
      safs_pkg::OP_WR_DESC: begin
        fc = (r.num_frames > NFRM) ? NFRM : int'(r.num_frames);
        ls = (r.loop_first >= fc) ? 0 : int'(r.loop_first);
        anim_cnt[a]  = fc;
        anim_ls[a]   = ls;
        anim_mode[a] = r.playback_mode;
      end
      safs_pkg::OP_WR_FRAME: begin
        if (r.frame_slot < NFRM) begin
          frm_dur[a][r.frame_slot]  = r.duration;
          frm_cell[a][r.frame_slot] = r.cell_id;
        end
      end
      default: begin
        if (anim_cnt[a] == 0) begin
          e = '{status: 1'b1, shown_frame: '0, shown_cell: '0};
        end else begin
          if (safs_pkg::op_t'(r.op) == safs_pkg::OP_Q_INDEX) begin
            sel = r.frame_slot % anim_cnt[a];
          end else begin
            t = (r.tick < 0) ? 0 : longint'(r.tick);
            case (anim_mode[a])
              safs_pkg::MODE_FWD_LOOP: sel = pick_fwd(a, t, 1'b1);
              safs_pkg::MODE_PP_ONCE:  sel = pick_pp(a, t, 1'b0);
              safs_pkg::MODE_PP_LOOP:  sel = pick_pp(a, t, 1'b1);
              default:                 sel = pick_fwd(a, t, 1'b0);
            endcase
            if (sel < 0 || sel >= int'(anim_cnt[a])) sel = 0;
          end
          e = '{status: 1'b0, shown_frame: sel[5:0], shown_cell: frm_cell[a][sel]};
        end
        expected_rsps.push_back(e);
      end
    endcase
  endfunction

  // request builders; unused fields carry random bits
  function automatic safs_pkg::req_t noise_req();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return bits[$bits(safs_pkg::req_t)-1:0];
  endfunction

  function automatic void add_desc(int a, int fc, int ls, int mode);
    safs_pkg::req_t r = noise_req();
    r.op = safs_pkg::OP_WR_DESC; r.anim_index = 3'(a);
    r.num_frames = 7'(fc); r.loop_first = 6'(ls); r.playback_mode = 3'(mode);
    gen_cnt[a] = (fc > NFRM) ? NFRM : fc;
    pending_reqs.push_back(r);
  endfunction

  function automatic void add_frame(int a, int fi, int dur, int cid);
    safs_pkg::req_t r = noise_req();
    r.op = safs_pkg::OP_WR_FRAME; r.anim_index = 3'(a);
    r.frame_slot = 16'(fi); r.duration = 16'(dur); r.cell_id = 16'(cid);
    if (fi < NFRM) gen_written[a][fi] = 1'b1;
    pending_reqs.push_back(r);
  endfunction

  function automatic void add_tick(int a, logic [31:0] tk);
    safs_pkg::req_t r = noise_req();
    r.op = safs_pkg::OP_Q_TICK; r.anim_index = 3'(a); r.tick = tk;
    pending_reqs.push_back(r);
  endfunction

  function automatic void add_index(int a, int fi);
    safs_pkg::req_t r = noise_req();
    r.op = safs_pkg::OP_Q_INDEX; r.anim_index = 3'(a); r.frame_slot = 16'(fi);
    pending_reqs.push_back(r);
  endfunction

  // a query must never touch a frame slot that was not loaded
  function automatic bit fully_loaded(int a);
    for (int i = 0; i < int'(gen_cnt[a]); i++)
      if (!gen_written[a][i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_dur();
    int r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return ($urandom_range(1) != 0) ? 65535 : $urandom_range(65535);
    return $urandom_range(1, 20);
  endfunction

  function automatic int random_block();
    int a = $urandom_range(NANIM - 1);
    int n = 0;
    int fc, k;
    logic [31:0] tk;
    if (!fully_loaded(a) || $urandom_range(3) == 0) begin
      fc = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(1, 8);
      add_desc(a, fc, ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(7),
               $urandom_range(7));
      n++;
      for (int i = 0; i < int'(gen_cnt[a]); i++) begin
        add_frame(a, i, pick_dur(), $urandom_range(65535));
        n++;
      end
      if ($urandom_range(9) == 0)
        add_frame(a, $urandom_range(NFRM, 65535), $urandom_range(65535),
                  $urandom_range(65535));
    end
    k = $urandom_range(1, 6);
    for (int q = 0; q < k; q++) begin
      if ($urandom_range(3) == 0) begin
        add_index(a, $urandom_range(65535));
      end else begin
        case ($urandom_range(3))
          0: tk = $urandom;
          1: tk = $urandom_range(50);
          2: tk = $urandom_range(2000);
          default: tk = $urandom_range(200000);
        endcase
        add_tick(a, tk);
      end
      n++;
    end
    return n;
  endfunction

  // request driver: change inputs on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
      if (!req_valid || taken) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
          req       <= pending_reqs[0];
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
      taken = 1'b0;
    end
  end

  // accept requests and check responses on the rising edge
  always @(posedge clk) begin
    cycles++;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        apply_request(pending_reqs.pop_front());
        taken = 1'b1;
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          report("unexpected response status", int'(rsp.status), -1);
        end else begin
          safs_pkg::rsp_t e;
          e = expected_rsps.pop_front();
          if (rsp.status !== e.status)
            report("status", int'(rsp.status), int'(e.status));
          if (rsp.shown_frame !== e.shown_frame)
            report("shown_frame", int'(rsp.shown_frame), int'(e.shown_frame));
          if (rsp.shown_cell !== e.shown_cell)
            report("shown_cell", int'(rsp.shown_cell), int'(e.shown_cell));
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL sprite_animation_frame_select_unit");
      $finish;
    end
  end

  initial begin
    int sent;
    rst       = 1'b1;
    req_valid = 1'b0;
    rsp_stall = 1'b0;
    req       = '0;
    taken     = 1'b0;
    send_idle = 33;
    recv_idle = 68;
    foreach (anim_cnt[i]) begin
      anim_cnt[i] = 0; anim_ls[i] = 0; anim_mode[i] = '0; gen_cnt[i] = 0;
      foreach (gen_written[i][j]) begin
        gen_written[i][j] = 1'b0; frm_dur[i][j] = '0; frm_cell[i][j] = '0;
      end
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty animation answers with an error
    add_tick(0, 32'd5);
    add_index(0, 0);
    // all durations zero; loop start past count drops to zero
    add_desc(1, 3, 5, 0);
    add_frame(1, 0, 0, 16'h1111);
    add_frame(1, 1, 0, 16'h2222);
    add_frame(1, 2, 0, 16'h3333);
    add_tick(1, 32'd100);
    add_frame(1, 1, 65535, 16'hFFFF);
    add_frame(1, 2, 7, 16'h0000);
    add_frame(1, 64, 3, 16'hABCD);
    add_frame(1, 65535, 3, 16'hABCD);
    add_tick(1, 32'h8000_0000);
    add_tick(1, 32'h7FFF_FFFF);
    add_index(1, 65535);
    add_desc(1, 3, 1, int'(safs_pkg::MODE_FWD_LOOP));
    add_tick(1, 32'h7FFF_FFFF);
    add_desc(1, 3, 1, int'(safs_pkg::MODE_PP_ONCE));
    add_tick(1, 32'd65540);
    add_desc(1, 3, 1, int'(safs_pkg::MODE_PP_LOOP));
    add_tick(1, 32'h7FFF_FFFF);
    add_desc(1, 3, 2, 7);
    add_tick(1, 32'd65534);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 33 : (ph == 1) ? 68 : 0;
      recv_idle = (ph == 0) ? 68 : (ph == 1) ? 33 : 0;
      sent = 0;
      while (sent < 570) sent += random_block();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
    end

    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0)
      $display("PASS sprite_animation_frame_select_unit");
    else
      $display("FAIL sprite_animation_frame_select_unit");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/safs_pkg.sv
rtl/core/safs_divider.sv
rtl/core/sprite_animation_frame_select_unit.sv
bench/tb_sprite_animation_frame_select_unit.sv
